// ----- design/aafp_pkg.sv -----
// aafp_pkg: shared constants, types and the digit decode for the attitude frame parser
`default_nettype none

package aafp_pkg;

    // framing bytes
    localparam logic [7:0] HEADER_BYTE  = 8'h40;
    localparam logic [7:0] TRAILER_BYTE = 8'h2A;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] ZERO_BYTE    = 8'h30;

    // frame geometry
    localparam int PAYLOAD_LEN = 15;
    localparam int FIELD_LEN   = 5;
    localparam int POS_W       = 5;

    localparam logic [POS_W-1:0] POS_IDLE    = 5'd0;
    localparam logic [POS_W-1:0] POS_LAST    = 5'd15;
    localparam logic [POS_W-1:0] POS_TRAILER = 5'd16;

    // widths
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 9;
    localparam int SUM_W   = 24;
    localparam int ANGLE_W = 23;
    localparam int OUT_TDATA_W = 72;

    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic signed [DIGIT_W-1:0] digit_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // angle offsets
    localparam sum_t PITCH_OFFSET = 24'sd18000;
    localparam sum_t ROLL_OFFSET  = 24'sd9000;
    localparam sum_t YAW_OFFSET   = 24'sd18000;

    // decimal weight of each character in a field, most significant first
    function automatic sum_t digit_weight(input logic [2:0] idx);
        sum_t w;
        case (idx)
            3'd0:    w = 24'sd10000;
            3'd1:    w = 24'sd1000;
            3'd2:    w = 24'sd100;
            3'd3:    w = 24'sd10;
            3'd4:    w = 24'sd1;
            default: w = 24'sd0;
        endcase
        return w;
    endfunction

    // space reads as zero, anything else is code minus the zero character
    function automatic digit_t char_value(input byte_t c);
        digit_t d;
        if (c == SPACE_BYTE) begin
            d = '0;
        end else begin
            d = digit_t'({1'b0, c}) - digit_t'({1'b0, ZERO_BYTE});
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- design/aafp_cell.sv -----
// aafp_cell: one payload byte cell of the shift chain, with its digit decode
`default_nettype none

module aafp_cell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire aafp_pkg::byte_t byte_in,
    output aafp_pkg::byte_t      byte_out,
    output aafp_pkg::digit_t     digit_out
);

    aafp_pkg::byte_t  byte_reg;
    aafp_pkg::byte_t  byte_next;
    aafp_pkg::digit_t digit_reg;
    aafp_pkg::digit_t digit_next;

    // take the neighbor's byte on each payload beat
    always_comb begin
        byte_next  = shift_en ? byte_in : byte_reg;
        digit_next = shift_en ? aafp_pkg::char_value(byte_in) : digit_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        digit_reg <= digit_next;
    end

    assign byte_out  = byte_reg;
    assign digit_out = digit_reg;

endmodule

`default_nettype wire

// ----- design/aafp_field_sum.sv -----
// aafp_field_sum: weighted sum of the five digits of one decimal field
`default_nettype none

module aafp_field_sum (
    input  wire aafp_pkg::digit_t digit_in [aafp_pkg::FIELD_LEN],
    output aafp_pkg::sum_t        field_out
);

    aafp_pkg::sum_t term [aafp_pkg::FIELD_LEN];

    // constant-weight products, summed
    always_comb begin
        field_out = '0;
        for (int j = 0; j < aafp_pkg::FIELD_LEN; j++) begin
            term[j] = aafp_pkg::sum_t'(
                {{(aafp_pkg::SUM_W-aafp_pkg::DIGIT_W){digit_in[j][aafp_pkg::DIGIT_W-1]}},
                 digit_in[j]} * aafp_pkg::digit_weight(3'(j)));
            field_out = field_out + term[j];
        end
    end

endmodule

`default_nettype wire

// ----- design/ascii_attitude_frame_parser_core.sv -----
// ascii_attitude_frame_parser_core: '@' + 15 payload + '*' framing, three angle fields out
//
//  channel | dir | tdata bits (low first)                               | beats
//  s_      | in  | [7:0] rx_byte                                        | one per byte
//  m_      | out | [22:0] pitch, [45:23] roll, [68:46] yaw, [71:69] zero | one per good frame
//
// one input beat a cycle while s_tready is high; each payload byte shifts into a row of 15 byte cells
// a good trailer loads the output register the same cycle; result shows next cycle
// s_tready drops only while a result waits and m_tready is low (one output register)
// aresetn (synchronous) returns the parser to idle and drops m_tvalid
`default_nettype none

module ascii_attitude_frame_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [22:0] pitch, [45:23] roll, [68:46] yaw, pad
);

    logic [aafp_pkg::POS_W-1:0] pos_reg;
    logic [aafp_pkg::POS_W-1:0] pos_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    aafp_pkg::angle_t           pitch_reg, roll_reg, yaw_reg;
    aafp_pkg::angle_t           pitch_next, roll_next, yaw_next;

    logic s_beat;
    logic in_payload;
    logic good_trailer;

    aafp_pkg::byte_t  cell_byte  [aafp_pkg::PAYLOAD_LEN];
    aafp_pkg::digit_t cell_digit [aafp_pkg::PAYLOAD_LEN];
    aafp_pkg::digit_t fld_digit  [3][aafp_pkg::FIELD_LEN];
    aafp_pkg::sum_t   fld_sum    [3];
    aafp_pkg::sum_t   pitch_full, roll_full, yaw_full;

    assign s_tready     = !m_valid_reg || m_tready;
    assign s_beat       = s_tvalid && s_tready;
    assign in_payload   = (pos_reg != aafp_pkg::POS_IDLE) && (pos_reg <= aafp_pkg::POS_LAST);
    assign good_trailer = (pos_reg == aafp_pkg::POS_TRAILER)
                          && (s_tdata == aafp_pkg::TRAILER_BYTE);

    // byte cell chain: cell 0 takes the new byte, the oldest byte sits in the last cell
    for (genvar k = 0; k < aafp_pkg::PAYLOAD_LEN; k++) begin : g_cell
        aafp_cell u_cell (
            .aclk      (aclk),
            .shift_en  (s_beat && in_payload),
            .byte_in   ((k == 0) ? s_tdata : cell_byte[(k == 0) ? 0 : k-1]),
            .byte_out  (cell_byte[k]),
            .digit_out (cell_digit[k])
        );
    end

    // field f, character j is payload byte 5f+j, held in cell 14-5f-j
    for (genvar f = 0; f < 3; f++) begin : g_field
        for (genvar j = 0; j < aafp_pkg::FIELD_LEN; j++) begin : g_dig
            assign fld_digit[f][j] =
                cell_digit[aafp_pkg::PAYLOAD_LEN-1-aafp_pkg::FIELD_LEN*f-j];
        end
        aafp_field_sum u_sum (
            .digit_in  (fld_digit[f]),
            .field_out (fld_sum[f])
        );
    end

    // angle offsets
    assign pitch_full = aafp_pkg::PITCH_OFFSET - fld_sum[0];
    assign roll_full  = fld_sum[1] - aafp_pkg::ROLL_OFFSET;
    assign yaw_full   = fld_sum[2] - aafp_pkg::YAW_OFFSET;

    // frame position sequencing
    always_comb begin
        pos_next = pos_reg;
        if (s_beat) begin
            if (pos_reg == aafp_pkg::POS_IDLE) begin
                if (s_tdata == aafp_pkg::HEADER_BYTE) begin
                    pos_next = aafp_pkg::POS_IDLE + 5'd1;
                end
            end else if (in_payload) begin
                pos_next = pos_reg + 5'd1;
            end else begin
                pos_next = aafp_pkg::POS_IDLE;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        pitch_next   = pitch_reg;
        roll_next    = roll_reg;
        yaw_next     = yaw_reg;
        if (s_beat && good_trailer) begin
            m_valid_next = 1'b1;
            pitch_next   = pitch_full[aafp_pkg::ANGLE_W-1:0];
            roll_next    = roll_full[aafp_pkg::ANGLE_W-1:0];
            yaw_next     = yaw_full[aafp_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= aafp_pkg::POS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pitch_reg <= pitch_next;
        roll_reg  <= roll_next;
        yaw_reg   <= yaw_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, yaw_reg, roll_reg, pitch_reg};

    // checks
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= aafp_pkg::POS_TRAILER)
        else $error("frame position beyond trailer slot");

    a_result_from_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (s_beat && good_trailer))
        else $error("result raised without a good trailer beat");

    a_idle_non_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && pos_reg == aafp_pkg::POS_IDLE && s_tdata != aafp_pkg::HEADER_BYTE)
        |=> pos_reg == aafp_pkg::POS_IDLE)
        else $error("non-header byte left idle");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_trailer_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && pos_reg == aafp_pkg::POS_TRAILER) |=> pos_reg == aafp_pkg::POS_IDLE)
        else $error("trailer slot did not return to idle");

endmodule

`default_nettype wire
